// File: design/cbd_pkg.sv
// ----------------------------------------------------------------------------
// Chroma 4:2:0 box downsampler package
// Shared constants and types for the downsampler and its pair-sum storage.
// ----------------------------------------------------------------------------
package cbd_pkg;

   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int MAX_HEIGHT        = 4096;
   localparam int ROW_W             = 12;
   localparam int CFG_W             = 13;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int PIX_W             = 8;
   localparam int SUM_W             = 9;
   localparam int POS_W             = 11;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   localparam logic KIND_LUMA   = 1'b0;
   localparam logic KIND_CHROMA = 1'b1;

   typedef struct packed {
      logic [PIX_W-1:0] luma;
      logic             has_chroma;
      logic             use_top;
      logic [1:0]       shift;
      logic [SUM_W-1:0] cr_sum;
      logic [SUM_W-1:0] cb_sum;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
   } work_type;

   typedef struct packed {
      logic             kind;
      logic [PIX_W-1:0] luma;
      logic [PIX_W-1:0] cb;
      logic [PIX_W-1:0] cr;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic             last;
   } result_type;

endpackage

// File: design/cbd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cbd_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 2048,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/chroma_420_box_downsampler_unit.sv
// A pixel's luma result leaves through the work stage and then the result register;
// its chroma result, if any, follows it out of the result register.
// Throughput: one pixel per cycle while the output is not stalled, set by the single
// output register; a block-closing pixel holds the work stage for both results.
// Reset clears the scan position and restores a 640x480 frame; the pair-sum RAM is
// not cleared, since each entry is written on an even row before an odd row reads it.
// ----------------------------------------------------------------------------
// Chroma 4:2:0 box downsampler
// Passes luma through and averages each 2x2 chroma block into one Cb/Cr sample.
// ----------------------------------------------------------------------------
module chroma_420_box_downsampler_unit #(
   parameter int MAX_WIDTH = cbd_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cbd_pkg::PIX_W-1:0]       req_luma_in,
   input  logic [cbd_pkg::PIX_W-1:0]       req_cr_in,
   input  logic [cbd_pkg::PIX_W-1:0]       req_cb_in,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_kind,
   output logic [cbd_pkg::PIX_W-1:0]       rsp_luma_out,
   output logic [cbd_pkg::PIX_W-1:0]       rsp_cb_out,
   output logic [cbd_pkg::PIX_W-1:0]       rsp_cr_out,
   output logic [cbd_pkg::POS_W-1:0]       rsp_chroma_col,
   output logic [cbd_pkg::POS_W-1:0]       rsp_chroma_row,
   output logic                            rsp_last,

   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cbd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cbd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cbd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int XW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW    = XW + 1;
   localparam int DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = 2 * cbd_pkg::SUM_W;
   localparam int YW    = cbd_pkg::ROW_W;
   localparam int HW    = cbd_pkg::CFG_W;

   logic [HW-1:0]                frame_width_ff, frame_width_in;
   logic [HW-1:0]                frame_height_ff, frame_height_in;
   logic [XW-1:0]                x_ff, x_in;
   logic [YW-1:0]                y_ff, y_in;
   logic [2*cbd_pkg::PIX_W-1:0]  left_ff, left_in;
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_phase_ff, s1_phase_in;
   cbd_pkg::work_type            s1_ff, s1_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   cbd_pkg::result_type          rsp_ff, rsp_in;

   cbd_pkg::reg_index_type       csr_index;
   logic                         csr_write;
   logic                         accept;
   logic [EW-1:0]                w_eff;
   logic [HW-1:0]                h_eff;
   logic                         x_last, x_wrap, y_last, y_wrap;
   logic                         pair_start, top_write;
   logic [cbd_pkg::SUM_W-1:0]    cr_sum, cb_sum;
   logic                         ram_we, ram_re;
   logic [AW-1:0]                ram_addr;
   logic [RW-1:0]                ram_rd_data;
   logic                         out_load, s1_finish;
   logic [cbd_pkg::SUM_W:0]      cr_tot, cb_tot;

   // Configuration port.
   assign csr_index  = cbd_pkg::reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_index)
         cbd_pkg::REG_FRAME_WIDTH: begin
            csr_prdata = cbd_pkg::CSR_DATA_W'(frame_width_ff);
         end
         cbd_pkg::REG_FRAME_HEIGHT: begin
            csr_prdata = cbd_pkg::CSR_DATA_W'(frame_height_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write && csr_index == cbd_pkg::REG_FRAME_WIDTH) begin
         frame_width_in = csr_pwdata[HW-1:0];
      end
      if (csr_write && csr_index == cbd_pkg::REG_FRAME_HEIGHT) begin
         frame_height_in = csr_pwdata[HW-1:0];
      end
   end

   // Effective frame size.
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = EW'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = EW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(frame_height_ff) > 32'(cbd_pkg::MAX_HEIGHT)) begin
         h_eff = HW'(cbd_pkg::MAX_HEIGHT);
      end else begin
         h_eff = frame_height_ff;
      end
   end

   assign accept     = req_valid && req_ready;
   assign x_last     = (EW'(x_ff) == w_eff - EW'(1));
   assign x_wrap     = (EW'(x_ff) + EW'(1) >= w_eff);
   assign y_last     = (HW'(y_ff) == h_eff - HW'(1));
   assign y_wrap     = (HW'(y_ff) + HW'(1) >= h_eff);
   assign pair_start = !x_ff[0] && !x_last;
   assign top_write  = !y_ff[0] && !y_last;

   assign cr_sum = cbd_pkg::SUM_W'(req_cr_in)
                 + (x_ff[0] ? cbd_pkg::SUM_W'(left_ff[15:8]) : '0);
   assign cb_sum = cbd_pkg::SUM_W'(req_cb_in)
                 + (x_ff[0] ? cbd_pkg::SUM_W'(left_ff[7:0]) : '0);

   assign ram_addr = AW'(x_ff >> 1);
   assign ram_we   = accept && !pair_start && top_write;
   assign ram_re   = accept && !pair_start && y_ff[0];

   cbd_ram #(
      .WIDTH (RW),
      .DEPTH (DEPTH)
   ) u_pair_sums (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data ({cr_sum, cb_sum}),
      .rd_en   (ram_re),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   // Scan position and the left pixel of the current pair.
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      left_in = left_ff;
      if (accept) begin
         if (pair_start) begin
            left_in = {req_cr_in, req_cb_in};
         end
         if (x_wrap) begin
            x_in = '0;
            y_in = y_wrap ? '0 : y_ff + YW'(1);
         end else begin
            x_in = x_ff + XW'(1);
         end
      end
      if (csr_write) begin
         x_in = '0;
         y_in = '0;
      end
   end

   // Work stage.
   always_comb begin
      s1_in            = s1_ff;
      if (accept) begin
         s1_in.luma       = req_luma_in;
         s1_in.has_chroma = !pair_start && !top_write;
         s1_in.use_top    = y_ff[0];
         s1_in.shift      = 2'(x_ff[0]) + 2'(y_ff[0]);
         s1_in.cr_sum     = cr_sum;
         s1_in.cb_sum     = cb_sum;
         s1_in.col        = cbd_pkg::POS_W'(x_ff >> 1);
         s1_in.row        = cbd_pkg::POS_W'(y_ff >> 1);
      end
   end

   assign out_load  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_finish = out_load && (!s1_ff.has_chroma || s1_phase_ff);
   assign req_ready = !s1_valid_ff || s1_finish;

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_finish) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (accept || s1_finish) begin
         s1_phase_in = 1'b0;
      end else if (out_load) begin
         s1_phase_in = 1'b1;
      end else begin
         s1_phase_in = s1_phase_ff;
      end
   end

   assign cr_tot = (cbd_pkg::SUM_W + 1)'(s1_ff.cr_sum)
                 + (s1_ff.use_top ? (cbd_pkg::SUM_W + 1)'(ram_rd_data[RW-1:cbd_pkg::SUM_W])
                                  : '0);
   assign cb_tot = (cbd_pkg::SUM_W + 1)'(s1_ff.cb_sum)
                 + (s1_ff.use_top ? (cbd_pkg::SUM_W + 1)'(ram_rd_data[cbd_pkg::SUM_W-1:0])
                                  : '0);

   // Result register.
   always_comb begin
      rsp_in = rsp_ff;
      if (out_load) begin
         if (s1_phase_ff) begin
            rsp_in.kind = cbd_pkg::KIND_CHROMA;
            rsp_in.luma = '0;
            rsp_in.cb   = cbd_pkg::PIX_W'(cb_tot >> s1_ff.shift);
            rsp_in.cr   = cbd_pkg::PIX_W'(cr_tot >> s1_ff.shift);
            rsp_in.col  = s1_ff.col;
            rsp_in.row  = s1_ff.row;
            rsp_in.last = 1'b1;
         end else begin
            rsp_in.kind = cbd_pkg::KIND_LUMA;
            rsp_in.luma = s1_ff.luma;
            rsp_in.cb   = '0;
            rsp_in.cr   = '0;
            rsp_in.col  = '0;
            rsp_in.row  = '0;
            rsp_in.last = !s1_ff.has_chroma;
         end
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= cbd_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= cbd_pkg::FRAME_HEIGHT_RESET;
         x_ff            <= '0;
         y_ff            <= '0;
         left_ff         <= '0;
         s1_valid_ff     <= 1'b0;
         s1_phase_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         x_ff            <= x_in;
         y_ff            <= y_in;
         left_ff         <= left_in;
         s1_valid_ff     <= s1_valid_in;
         s1_phase_ff     <= s1_phase_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_ff.kind;
   assign rsp_luma_out   = rsp_ff.luma;
   assign rsp_cb_out     = rsp_ff.cb;
   assign rsp_cr_out     = rsp_ff.cr;
   assign rsp_chroma_col = rsp_ff.col;
   assign rsp_chroma_row = rsp_ff.row;
   assign rsp_last       = rsp_ff.last;

`ifndef SYNTH
   a_chroma_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == cbd_pkg::KIND_CHROMA |-> rsp_last)
      else $error("chroma result without last");

   a_chroma_follows_luma: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == cbd_pkg::KIND_LUMA && !rsp_last
      |=> rsp_valid && rsp_kind == cbd_pkg::KIND_CHROMA)
      else $error("luma result not followed by its chroma result");

   a_phase_has_chroma: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_phase_ff |-> s1_ff.has_chroma)
      else $error("chroma phase on a pixel that closes no block");

   a_ram_single_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("pair-sum RAM written and read by the same transfer");
`endif

endmodule

// File: sim/tb_chroma_420_box_downsampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the chroma 4:2:0 box downsampler
// Streams pixel frames of many sizes through the unit and predicts every luma
// and averaged chroma result cycle-independently, checking them in order.
// Frame sizes are set over the APB port between phases and read back. The
// sender works in bursts and the receiver stalls on patterns of its own,
// including one long hold-off that fills the unit.
// ----------------------------------------------------------------------------
module tb_chroma_420_box_downsampler_unit;

   localparam int MAX_W        = cbd_pkg::MAX_WIDTH_DEFAULT;
   localparam int PAIR_DEPTH   = (MAX_W + 1) / 2;
   localparam int RANDOM_ITEMS = 800;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int LIMIT_CYCLES = 1000000;

   typedef enum int {
      READY_ALWAYS,
      READY_HALF,
      READY_MOSTLY,
      READY_PERIODIC
   } ready_mode_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [cbd_pkg::PIX_W-1:0]      req_luma_in;
   logic [cbd_pkg::PIX_W-1:0]      req_cr_in;
   logic [cbd_pkg::PIX_W-1:0]      req_cb_in;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic                           rsp_kind;
   logic [cbd_pkg::PIX_W-1:0]      rsp_luma_out;
   logic [cbd_pkg::PIX_W-1:0]      rsp_cb_out;
   logic [cbd_pkg::PIX_W-1:0]      rsp_cr_out;
   logic [cbd_pkg::POS_W-1:0]      rsp_chroma_col;
   logic [cbd_pkg::POS_W-1:0]      rsp_chroma_row;
   logic                           rsp_last;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [cbd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [cbd_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [cbd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   logic [cbd_pkg::CFG_W-1:0]      cfg_width;
   logic [cbd_pkg::CFG_W-1:0]      cfg_height;
   int                             scan_col;
   int                             scan_row;
   logic [15:0]                    left_chroma;
   logic [17:0]                    pair_sums [PAIR_DEPTH];
   cbd_pkg::result_type            pending_results [$];

   int unsigned                    error_count   = 0;
   int                             burst_left    = 0;
   bit                             gaps_enabled  = 1'b1;
   int                             hold_requests = 0;

   chroma_420_box_downsampler_unit #(
      .MAX_WIDTH(MAX_W)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_luma_in    (req_luma_in),
      .req_cr_in      (req_cr_in),
      .req_cb_in      (req_cb_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_luma_out   (rsp_luma_out),
      .rsp_cb_out     (rsp_cb_out),
      .rsp_cr_out     (rsp_cr_out),
      .rsp_chroma_col (rsp_chroma_col),
      .rsp_chroma_row (rsp_chroma_row),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int effective_dim(input logic [cbd_pkg::CFG_W-1:0] value,
                                        input int cap);
      if (value == '0)
         return 1;
      if (int'(value) > cap)
         return cap;
      return int'(value);
   endfunction

   task automatic predict_pixel(input logic [7:0] luma, input logic [7:0] cr,
                                input logic [7:0] cb);
      int                  w;
      int                  h;
      int                  cx;
      int                  cr_sum;
      int                  cb_sum;
      int                  shift;
      bit                  emit;
      cbd_pkg::result_type luma_res;
      cbd_pkg::result_type chroma_res;
      w = effective_dim(cfg_width, MAX_W);
      h = effective_dim(cfg_height, cbd_pkg::MAX_HEIGHT);
      emit = 1'b0;
      luma_res = '0;
      luma_res.kind = cbd_pkg::KIND_LUMA;
      luma_res.luma = luma;
      luma_res.last = 1'b1;
      chroma_res = '0;
      if (scan_col % 2 == 0 && scan_col != w - 1) begin
         left_chroma = {cr, cb};
      end else begin
         cr_sum = cr;
         cb_sum = cb;
         shift = 0;
         cx = (scan_col / 2) % PAIR_DEPTH;
         if (scan_col % 2 == 1) begin
            cr_sum += left_chroma[15:8];
            cb_sum += left_chroma[7:0];
            shift = 1;
         end
         if (scan_row % 2 == 0 && scan_row != h - 1) begin
            pair_sums[cx] = {9'(cr_sum), 9'(cb_sum)};
         end else begin
            if (scan_row % 2 == 1) begin
               cr_sum += pair_sums[cx][17:9];
               cb_sum += pair_sums[cx][8:0];
               shift += 1;
            end
            emit = 1'b1;
            luma_res.last = 1'b0;
            chroma_res.kind = cbd_pkg::KIND_CHROMA;
            chroma_res.cb = 8'(cb_sum >> shift);
            chroma_res.cr = 8'(cr_sum >> shift);
            chroma_res.col = cbd_pkg::POS_W'(scan_col / 2);
            chroma_res.row = cbd_pkg::POS_W'(scan_row / 2);
            chroma_res.last = 1'b1;
         end
      end
      pending_results.insert(pending_results.size(), luma_res);
      if (emit)
         pending_results.insert(pending_results.size(), chroma_res);
      scan_col++;
      if (scan_col >= w) begin
         scan_col = 0;
         scan_row++;
         if (scan_row >= h)
            scan_row = 0;
      end
   endtask

   task automatic check_field(input string name, input int want_value, input int got_value);
      if (want_value != got_value) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                  want_value, got_value);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      cbd_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d luma %0d",
                     $time, rsp_kind, rsp_luma_out);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("luma_out", want.luma, rsp_luma_out);
            check_field("cb_out", want.cb, rsp_cb_out);
            check_field("cr_out", want.cr, rsp_cr_out);
            check_field("chroma_col", want.col, rsp_chroma_col);
            check_field("chroma_row", want.row, rsp_chroma_row);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   initial begin
      ready_mode_type mode;
      int             mode_left;
      int             hold_left;
      int             hold_served;
      int             phase_count;
      mode = READY_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      hold_served = 0;
      phase_count = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = ready_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase_count++;
            case (mode)
               READY_ALWAYS: begin
                  rsp_ready = 1'b1;
               end
               READY_HALF: begin
                  rsp_ready = 1'($urandom_range(0, 1));
               end
               READY_MOSTLY: begin
                  rsp_ready = ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_ready = (phase_count % 5) < 2;
               end
            endcase
         end
      end
   end

   task automatic send_pixel(input logic [7:0] luma, input logic [7:0] cr,
                             input logic [7:0] cb);
      int gap;
      if (burst_left == 0) begin
         if (gaps_enabled) begin
            gap = $urandom_range(1, 6);
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid = 1'b1;
      req_luma_in = luma;
      req_cr_in = cr;
      req_cb_in = cb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pixel(luma, cr, cb);
      burst_left--;
      @(negedge clock);
   endtask

   function automatic logic [7:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_random_pixels(input int count);
      repeat (count) send_pixel(random_sample(), random_sample(), random_sample());
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input cbd_pkg::reg_index_type idx, input logic [31:0] value);
      logic [31:0] readback;
      wait_idle();
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = cbd_pkg::CSR_ADDR_W'(int'(idx) * 4);
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         cbd_pkg::REG_FRAME_WIDTH: cfg_width = value[cbd_pkg::CFG_W-1:0];
         default: cfg_height = value[cbd_pkg::CFG_W-1:0];
      endcase
      scan_col = 0;
      scan_row = 0;
      @(negedge clock);
      csr_pwrite = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      if (readback != 32'(value[cbd_pkg::CFG_W-1:0])) begin
         $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
                  $time, int'(idx), value[cbd_pkg::CFG_W-1:0], readback);
         error_count++;
      end
   endtask

   task automatic set_frame(input int w, input int h);
      write_csr(cbd_pkg::REG_FRAME_WIDTH, 32'(w));
      write_csr(cbd_pkg::REG_FRAME_HEIGHT, 32'(h));
   endtask

   task automatic test_reset_defaults();
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_random_pixels(2);
   endtask

   task automatic test_odd_edges();
      set_frame(3, 3);
      send_pixel(8'h00, 8'hFF, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'h01);
      send_pixel(8'h80, 8'h7F, 8'hFE);
      send_pixel(8'h01, 8'hFF, 8'h00);
      send_pixel(8'h7F, 8'h00, 8'hFF);
      send_pixel(8'hFE, 8'h55, 8'hAA);
      send_pixel(8'hFF, 8'h01, 8'h02);
      send_pixel(8'h00, 8'hFF, 8'hFF);
      send_pixel(8'h40, 8'h03, 8'h80);
      send_pixel(8'hAA, 8'hFF, 8'hFF);
      send_pixel(8'h55, 8'h00, 8'h00);
      set_frame(2, 2);
      repeat (4) send_pixel(8'hFF, 8'hFF, 8'hFF);
   endtask

   task automatic test_zero_size();
      write_csr(cbd_pkg::REG_FRAME_WIDTH, 32'hFFFF_E000);
      write_csr(cbd_pkg::REG_FRAME_HEIGHT, 32'h0000_2000);
      send_pixel(8'h12, 8'hFF, 8'h00);
      send_pixel(8'hED, 8'h00, 8'hFF);
      send_random_pixels(1);
   endtask

   task automatic test_extreme_sizes();
      gaps_enabled = 1'b0;
      set_frame(MAX_W, 1);
      send_random_pixels(40);
      set_frame(32'h1FFF, 2);
      send_random_pixels(6);
      set_frame(1, 32'h1FFF);
      send_random_pixels(40);
      gaps_enabled = 1'b1;
   endtask

   task automatic test_restart();
      set_frame(4, 4);
      send_random_pixels(6);
      write_csr(cbd_pkg::REG_FRAME_HEIGHT, 4);
      send_random_pixels(16);
      set_frame(5, 2);
      send_random_pixels(7);
      write_csr(cbd_pkg::REG_FRAME_WIDTH, 5);
      send_random_pixels(10);
   endtask

   task automatic test_backpressure();
      set_frame(5, 3);
      gaps_enabled = 1'b0;
      hold_requests++;
      send_random_pixels(60);
      gaps_enabled = 1'b1;
   endtask

   task automatic test_random_frames();
      int sent;
      int pick;
      int w;
      int h;
      int count;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick < 14)
            w = $urandom_range(1, 8);
         else if (pick < 19)
            w = $urandom_range(9, 40);
         else
            w = $urandom_range(41, 200);
         h = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
         gaps_enabled = ($urandom_range(0, 2) != 0);
         case ($urandom_range(0, 5))
            0: write_csr(cbd_pkg::REG_FRAME_WIDTH, 32'(w));
            1: ;
            default: set_frame(w, h);
         endcase
         count = w * h * $urandom_range(0, 2) + $urandom_range(1, w * h);
         if (count > 300)
            count = $urandom_range(200, 300);
         send_random_pixels(count);
         sent += count;
      end
      gaps_enabled = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_luma_in = '0;
      req_cr_in = '0;
      req_cb_in = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg_width = cbd_pkg::FRAME_WIDTH_RESET;
      cfg_height = cbd_pkg::FRAME_HEIGHT_RESET;
      scan_col = 0;
      scan_row = 0;
      left_chroma = '0;
      foreach (pair_sums[i]) pair_sums[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_odd_edges();
      test_zero_size();
      test_restart();
      test_backpressure();
      test_extreme_sizes();
      test_random_frames();

      wait_idle();
      repeat (20) @(negedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: sim.f
design/cbd_pkg.sv
design/cbd_ram.sv
design/chroma_420_box_downsampler_unit.sv
sim/tb_chroma_420_box_downsampler_unit.sv
